FILE: hw/rtl/slrl_pkg.sv
`timescale 1ns / 1ps
package slrl_pkg;

  // depth of the queue between the front and the back
  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  // fixed payload of one item, everything but the channel index
  typedef struct packed {
    logic signed [31:0] target;
    logic        [30:0] rate_up;
    logic        [30:0] rate_down;
    logic signed [31:0] upper_limit;
    logic signed [31:0] lower_limit;
  } slrl_item_t;

  // status of the back part, seen at the top level
  typedef struct packed {
    logic busy;
    logic adv;
  } slrl_back_stat_t;

  // clamp the previous value, pick the rate, step toward the target
  function automatic logic signed [31:0] slrl_step(
    input logic signed [31:0] prev,
    input slrl_item_t         it
  );
    logic signed [31:0] p;
    logic signed [32:0] d;
    logic        [32:0] m;
    logic               use_up;
    logic        [30:0] rate;
    logic signed [32:0] moved;
    p = prev;
    if (p > it.upper_limit) p = it.upper_limit;
    if (p < it.lower_limit) p = it.lower_limit;
    d = 33'(it.target) - 33'(p);
    m = d[32] ? 33'(-d) : 33'(d);
    use_up = ((it.target > 0) && ((p < 0) || (it.target > p))) ||
             ((it.target < 0) && (p <= 0) && (it.target < p));
    rate = use_up ? it.rate_up : it.rate_down;
    // the step always heads toward the target, so it stays in range
    if (d[32]) begin
      moved = 33'(p) - 33'({2'b00, rate});
    end else begin
      moved = 33'(p) + 33'({2'b00, rate});
    end
    if (m > {2'b00, rate}) begin
      return moved[31:0];
    end
    return it.target;
  endfunction

endpackage

FILE: hw/rtl/slrl_ram.sv
`timescale 1ns / 1ps
module slrl_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: hw/rtl/slrl_front.sv
`timescale 1ns / 1ps
module slrl_front import slrl_pkg::*; #(
  parameter int unsigned NUM_CHANNELS = 16,
  parameter int unsigned IDX_W = 4
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [3:0]         channel,
  input  slrl_item_t         in_item,
  output logic               q_valid,
  input  logic               q_pop,
  output slrl_item_t         q_item,
  output logic [IDX_W-1:0]   q_idx
);

  logic [IDX_W-1:0]  chan_lut [16];
  slrl_item_t        item_q [QDEPTH];
  logic [IDX_W-1:0]  idx_q [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              push;
  logic              pop;

  // channel folding table, worked out at elaboration
  for (genvar k = 0; k < 16; k++) begin : g_lut
    localparam int unsigned MK = k % NUM_CHANNELS;
    assign chan_lut[k] = IDX_W'(MK);
  end

  assign in_stall = (count == QCNT_W'(QDEPTH));
  assign push     = in_valid && !in_stall;
  assign q_valid  = (count != '0);
  assign pop      = q_pop && q_valid;
  assign q_item   = item_q[rd_ptr];
  assign q_idx    = idx_q[rd_ptr];

  // queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      item_q[wr_ptr] <= in_item;
      idx_q[wr_ptr]  <= chan_lut[channel];
    end
  end

  // queue pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

FILE: hw/rtl/slrl_back.sv
`timescale 1ns / 1ps
module slrl_back import slrl_pkg::*; #(
  parameter int unsigned NUM_CHANNELS = 16,
  parameter int unsigned IDX_W = 4
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_valid,
  output logic               q_pop,
  input  slrl_item_t         q_item,
  input  logic [IDX_W-1:0]   q_idx,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] limited,
  output slrl_back_stat_t    stat
);

  logic                     b_vld;
  slrl_item_t               b_item;
  logic [IDX_W-1:0]         b_idx;
  logic [NUM_CHANNELS-1:0]  seen;
  logic                     lw_vld;
  logic [IDX_W-1:0]         lw_idx;
  logic signed [31:0]       lw_val;
  logic [31:0]              rd;
  logic signed [31:0]       prev;
  logic signed [31:0]       res;
  logic                     adv;
  logic                     load;

  assign adv   = b_vld && (!out_valid || !out_stall);
  assign load  = q_valid && (!b_vld || adv);
  assign q_pop = load;
  assign stat  = '{busy: b_vld, adv: adv};

  // per-channel state, read when an item leaves the queue
  slrl_ram #(
    .WIDTH (32),
    .DEPTH (NUM_CHANNELS),
    .AW    (IDX_W)
  ) u_state (
    .clk   (clk),
    .we    (adv),
    .waddr (b_idx),
    .wdata (res),
    .re    (load),
    .raddr (q_idx),
    .rdata (rd)
  );

  // newest write wins, unwritten channels read as zero
  always_comb begin
    if (lw_vld && (lw_idx == b_idx)) begin
      prev = lw_val;
    end else if (seen[b_idx]) begin
      prev = $signed(rd);
    end else begin
      prev = '0;
    end
  end

  assign res = slrl_step(prev, b_item);

  // payload registers
  always_ff @(posedge clk) begin
    if (load) begin
      b_item <= q_item;
      b_idx  <= q_idx;
    end
    if (adv) begin
      lw_idx  <= b_idx;
      lw_val  <= res;
      limited <= res;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      b_vld     <= 1'b0;
      out_valid <= 1'b0;
      lw_vld    <= 1'b0;
      seen      <= '0;
    end else begin
      if (load) begin
        b_vld <= 1'b1;
      end else if (adv) begin
        b_vld <= 1'b0;
      end
      if (adv) begin
        out_valid    <= 1'b1;
        lw_vld       <= 1'b1;
        seen[b_idx]  <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

FILE: hw/rtl/multichannel_slew_rate_limiter_top.sv
`timescale 1ns / 1ps
// path: queue, then the back part's item register, then the output register
// throughput: one item per cycle while not stalled, set by the channel state
// memory read-modify-write; last write forwarded to the next same-channel item
// reset: synchronous; empties the queue and pipeline and clears the per-channel
// written flags, so every channel reads zero with no clearing pass
module multichannel_slew_rate_limiter_top import slrl_pkg::*; #(
  parameter int unsigned NUM_CHANNELS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [3:0]         channel,
  input  logic signed [31:0] target,
  input  logic [30:0]        rate_up,
  input  logic [30:0]        rate_down,
  input  logic signed [31:0] upper_limit,
  input  logic signed [31:0] lower_limit,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] limited
);

  localparam int unsigned IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

  slrl_item_t      in_item;
  slrl_item_t      q_item;
  logic            q_valid;
  logic            q_pop;
  logic [IDX_W-1:0] q_idx;
  slrl_back_stat_t stat;

  assign in_item = '{target: target, rate_up: rate_up, rate_down: rate_down,
                     upper_limit: upper_limit, lower_limit: lower_limit};

  // accept, fold channel, queue
  slrl_front #(
    .NUM_CHANNELS (NUM_CHANNELS),
    .IDX_W        (IDX_W)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .channel  (channel),
    .in_item  (in_item),
    .q_valid  (q_valid),
    .q_pop    (q_pop),
    .q_item   (q_item),
    .q_idx    (q_idx)
  );

  // state lookup, slew step, output register
  slrl_back #(
    .NUM_CHANNELS (NUM_CHANNELS),
    .IDX_W        (IDX_W)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_pop     (q_pop),
    .q_item    (q_item),
    .q_idx     (q_idx),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .limited   (limited),
    .stat      (stat)
  );

  // pipeline is empty right after reset
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> (!stat.busy && !out_valid))
    else $error("pipeline not empty after reset");

  // a full queue always offers an item to the back
  a_full_has_head: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> q_valid)
    else $error("queue full but no head item");

  // results only move into a free or draining output register
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    stat.adv |-> (!out_valid || !out_stall))
    else $error("output register overwritten while stalled");

endmodule

FILE: tb/multichannel_slew_rate_limiter_top_tb.sv
`timescale 1ns / 1ps
module multichannel_slew_rate_limiter_top_tb;
  import slrl_pkg::*;

  localparam int NUM_CH = 16;
  localparam int HOLD_CYCLES = 150;
  localparam int SETTLE_CYCLES = 8;
  localparam int CYCLE_LIMIT = 200000;
  localparam int MAX_PRINTS = 50;

  localparam logic signed [31:0] Q_MAX = 32'sh7fffffff;
  localparam logic signed [31:0] Q_MIN = 32'sh80000000;
  localparam logic signed [31:0] ONE = 32'sh00010000;
  localparam logic [30:0] R_MAX = 31'h7fffffff;

  // one item as offered on the input side
  typedef struct packed {
    logic [3:0] channel;
    slrl_item_t f;
  } limiter_req_t;

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_stall;
  logic [3:0]         channel;
  logic signed [31:0] target;
  logic [30:0]        rate_up;
  logic [30:0]        rate_down;
  logic signed [31:0] upper_limit;
  logic signed [31:0] lower_limit;
  logic               out_valid;
  logic               out_stall;
  logic signed [31:0] limited;

  // predictor state and pending expected outputs
  logic signed [31:0] chan_last [NUM_CH];
  logic signed [31:0] limited_q [$];
  limiter_req_t       last_rand_req;

  int  err_count = 0;
  int  cycle_count = 0;
  int  send_idle_pct = 0;
  int  recv_idle_pct = 0;
  logic hold_on = 1'b0;

  multichannel_slew_rate_limiter_top #(
    .NUM_CHANNELS(NUM_CH)
  ) DUT (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .channel    (channel),
    .target     (target),
    .rate_up    (rate_up),
    .rate_down  (rate_down),
    .upper_limit(upper_limit),
    .lower_limit(lower_limit),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .limited    (limited)
  );

  // clock
  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("multichannel_slew_rate_limiter_top test failed");
      $finish;
    end
  end

  // receiver stall: random, or held during a hold-off
  always @(posedge clk) begin
    out_stall <= hold_on || ($urandom_range(99) < recv_idle_pct);
  end

  task automatic report_mismatch(input string what, input logic signed [31:0] got,
                                 input logic signed [31:0] want);
    err_count++;
    if (err_count <= MAX_PRINTS)
      $display("mismatch at cycle %0d: %s got %0d want %0d", cycle_count, what, got, want);
  endtask

  // compare each output item with the oldest expectation
  always @(posedge clk) begin
    logic signed [31:0] want;
    if (!rst && out_valid && !out_stall) begin
      if (limited_q.size() == 0) begin
        report_mismatch("unexpected output item", limited, 32'sd0);
      end else begin
        want = limited_q.pop_front();
        if (limited !== want) report_mismatch("limited", limited, want);
      end
    end
  end

  // move prev toward tgt by at most rate
  function automatic longint step_toward(input longint prev, input longint tgt,
                                         input longint rate, input bit rising);
    longint gap;
    gap = tgt - prev;
    if (gap < 0) gap = -gap;
    if (gap > rate) return rising ? prev + rate : prev - rate;
    return tgt;
  endfunction

  // clamp the stored value, pick the rate by direction of magnitude, slew, saturate
  function automatic logic signed [31:0] predict_limited(input limiter_req_t r);
    int unsigned idx;
    longint prev, tgt, rup, rdn, hi, lo, next;
    logic signed [31:0] res;
    idx = r.channel % NUM_CH;
    tgt = longint'($signed(r.f.target));
    rup = longint'({1'b0, r.f.rate_up});
    rdn = longint'({1'b0, r.f.rate_down});
    hi = longint'($signed(r.f.upper_limit));
    lo = longint'($signed(r.f.lower_limit));
    prev = longint'($signed(chan_last[idx]));
    if (prev > hi) prev = hi;
    if (prev < lo) prev = lo;
    if (tgt > 0 && prev >= 0) begin
      next = (tgt > prev) ? step_toward(prev, tgt, rup, 1'b1) : step_toward(prev, tgt, rdn, 1'b0);
    end else if (tgt < 0 && prev <= 0) begin
      next = (tgt < prev) ? step_toward(prev, tgt, rup, 1'b0) : step_toward(prev, tgt, rdn, 1'b1);
    end else if (tgt == 0) begin
      next = step_toward(prev, 0, rdn, prev <= 0);
    end else if (tgt > 0) begin
      next = step_toward(prev, tgt, rup, 1'b1);
    end else begin
      next = step_toward(prev, tgt, rdn, 1'b0);
    end
    if (next > longint'(Q_MAX)) res = Q_MAX;
    else if (next < longint'(Q_MIN)) res = Q_MIN;
    else res = next[31:0];
    chan_last[idx] = res;
    return res;
  endfunction

  // offer one item, wait for it to be taken, then record its expected output
  task automatic send_item(input limiter_req_t r);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    channel     <= r.channel;
    target      <= r.f.target;
    rate_up     <= r.f.rate_up;
    rate_down   <= r.f.rate_down;
    upper_limit <= r.f.upper_limit;
    lower_limit <= r.f.lower_limit;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    limited_q.push_back(predict_limited(r));
  endtask

  // stop offering and let every pending output item arrive
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (limited_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic limiter_req_t mk(input logic [3:0] ch, input logic signed [31:0] tgt,
                                      input logic [30:0] rup, input logic [30:0] rdn,
                                      input logic signed [31:0] hi,
                                      input logic signed [31:0] lo);
    limiter_req_t r;
    r.channel = ch;
    r.f.target = tgt;
    r.f.rate_up = rup;
    r.f.rate_down = rdn;
    r.f.upper_limit = hi;
    r.f.lower_limit = lo;
    return r;
  endfunction

  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(9))
      0, 1: return $urandom;
      2: begin
        case ($urandom_range(4))
          0: return Q_MAX;
          1: return Q_MIN;
          2: return 32'sd0;
          3: return 32'sd1;
          default: return -32'sd1;
        endcase
      end
      3, 4, 5: return int'($urandom_range(0, 2097152)) - 1048576;
      default: return (int'($urandom_range(0, 512)) - 256) * 65536;
    endcase
  endfunction

  function automatic logic [30:0] pick_rate();
    logic [31:0] w;
    case ($urandom_range(7))
      0: begin
        w = $urandom;
        return w[30:0];
      end
      1: return $urandom_range(1) ? R_MAX : 31'd0;
      default: return 31'($urandom_range(0, 262144));
    endcase
  endfunction

  // mostly fresh items, often repeated so a channel keeps slewing to one target
  function automatic limiter_req_t random_req();
    limiter_req_t r;
    logic signed [31:0] a, b;
    if ($urandom_range(99) < 35) return last_rand_req;
    r.channel = $urandom_range(1) ? 4'($urandom_range(3)) : 4'($urandom_range(15));
    r.f.target = pick_value();
    r.f.rate_up = pick_rate();
    r.f.rate_down = pick_rate();
    a = pick_value();
    b = pick_value();
    case ($urandom_range(19))
      12, 13, 14, 15, 16: begin
        r.f.upper_limit = (a > b) ? a : b;
        r.f.lower_limit = (a > b) ? b : a;
      end
      // crossed limits
      17, 18: begin
        r.f.upper_limit = (a > b) ? b : a;
        r.f.lower_limit = (a > b) ? a : b;
      end
      19: begin
        r.f.upper_limit = a;
        r.f.lower_limit = a;
      end
      default: begin
        r.f.upper_limit = Q_MAX;
        r.f.lower_limit = Q_MIN;
      end
    endcase
    last_rand_req = r;
    return r;
  endfunction

  // extremes and the corner cases of rate selection and clamping
  task automatic test_directed();
    limiter_req_t list [$];
    send_idle_pct = 11;
    recv_idle_pct = 59;
    // zero previous value counts as same sign, full up-rate reaches max
    list.push_back(mk(4'd0, Q_MAX, R_MAX, 31'd0, Q_MAX, Q_MIN));
    // crossing toward a negative target uses the down-rate
    list.push_back(mk(4'd0, Q_MIN, R_MAX, R_MAX, Q_MAX, Q_MIN));
    list.push_back(mk(4'd0, Q_MIN, R_MAX, 31'd0, Q_MAX, Q_MIN));
    list.push_back(mk(4'd0, Q_MIN, 31'd1, 31'd0, Q_MAX, Q_MIN));
    // zero target steps toward zero, then lands on it
    list.push_back(mk(4'd0, 32'sd0, R_MAX, 31'(5 * ONE), Q_MAX, Q_MIN));
    list.push_back(mk(4'd0, 32'sd0, 31'd0, R_MAX, Q_MAX, Q_MIN));
    // ramp up and settle on target, then hold at equal value
    list.push_back(mk(4'd1, 3 * ONE, 31'(ONE), 31'(ONE / 4), Q_MAX, Q_MIN));
    list.push_back(mk(4'd1, 3 * ONE, 31'(ONE), 31'(ONE / 4), Q_MAX, Q_MIN));
    list.push_back(mk(4'd1, 3 * ONE, 31'(ONE), 31'(ONE / 4), Q_MAX, Q_MIN));
    list.push_back(mk(4'd1, 3 * ONE, 31'(ONE), 31'(ONE / 4), Q_MAX, Q_MIN));
    // magnitude shrinks
    list.push_back(mk(4'd1, ONE, 31'(ONE), 31'(ONE / 4), Q_MAX, Q_MIN));
    list.push_back(mk(4'd1, -2 * ONE, 31'(3 * ONE), 31'(ONE / 2), Q_MAX, Q_MIN));
    // clamp to ceiling, then to floor
    list.push_back(mk(4'd1, 2 * ONE, 31'(ONE / 8), 31'(ONE), ONE, -ONE));
    list.push_back(mk(4'd1, -4 * ONE, 31'(ONE), 31'(ONE), Q_MAX, 2 * ONE));
    // crossed limits: floor wins
    list.push_back(mk(4'd2, ONE, 31'(ONE), 31'(ONE), -5 * ONE, 5 * ONE));
    // negative growth, then crossing toward positive uses the up-rate
    list.push_back(mk(4'd15, -ONE, 31'(ONE / 2), 31'(ONE), Q_MAX, Q_MIN));
    list.push_back(mk(4'd15, 3 * ONE, 31'(2 * ONE), 31'(ONE / 8), Q_MAX, Q_MIN));
    list.push_back(mk(4'd15, -ONE, R_MAX, R_MAX, Q_MAX, Q_MIN));
    // zero rates hold the value
    list.push_back(mk(4'd14, Q_MAX, 31'd0, 31'd0, Q_MAX, Q_MIN));
    list.push_back(mk(4'd14, Q_MIN, 31'd0, R_MAX, Q_MAX, Q_MIN));
    // degenerate limits at the extremes
    list.push_back(mk(4'd3, 32'sd0, 31'd0, 31'd0, Q_MIN, Q_MIN));
    list.push_back(mk(4'd3, Q_MAX, R_MAX, R_MAX, Q_MAX, Q_MAX));
    list.push_back(mk(4'd8, ONE, R_MAX, R_MAX, Q_MAX, Q_MIN));
    foreach (list[i]) send_item(list[i]);
    wait_drained();
  endtask

  task automatic test_random(input int n, input int s_pct, input int r_pct);
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    repeat (n) send_item(random_req());
    wait_drained();
  endtask

  // long receiver hold-off while the sender keeps offering
  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 20;
    fork
      begin
        hold_on <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_on <= 1'b0;
      end
    join_none
    repeat (40) send_item(random_req());
    wait_drained();
  endtask

  // sender stops mid-stream until all outputs are back, then resumes
  task automatic test_drain_pause();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    repeat (20) send_item(random_req());
    wait_drained();
    repeat (20) send_item(random_req());
    wait_drained();
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    out_stall = 1'b0;
    channel = '0;
    target = '0;
    rate_up = '0;
    rate_down = '0;
    upper_limit = '0;
    lower_limit = '0;
    foreach (chan_last[i]) chan_last[i] = '0;
    last_rand_req = mk(4'd0, 32'sd0, 31'd0, 31'd0, Q_MAX, Q_MIN);
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random(500, 11, 59);
    test_random(500, 59, 11);
    test_random(500, 0, 0);
    test_backpressure();
    test_drain_pause();
    if (err_count == 0) begin
      $display("multichannel_slew_rate_limiter_top test passed");
    end else begin
      $display("multichannel_slew_rate_limiter_top test failed");
    end
    $finish;
  end

endmodule
